// ----- hw/rtl/keypad_joystick_emulator_defines.svh -----
// Assertion macros shared by the keypad joystick emulator RTL.
// Both expect signals named clock and reset in the enclosing module.
`ifndef KEYPAD_JOYSTICK_EMULATOR_DEFINES_SVH
`define KEYPAD_JOYSTICK_EMULATOR_DEFINES_SVH

// Same-cycle implication.
`define KJE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kje assertion failed");

// Next-cycle implication.
`define KJE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kje assertion failed");

`endif

// ----- hw/rtl/kje_pkg.sv -----
`default_nettype none
package kje_pkg;

   typedef enum logic [2:0] {
      REQ_KEY    = 3'd0,
      REQ_TICK   = 3'd1,
      REQ_READ8  = 3'd2,
      REQ_READ16 = 3'd3,
      REQ_CAL_TR = 3'd4,
      REQ_CAL_BL = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_SWITCH = 2'd0,
      MODE_ANALOG = 2'd1,
      MODE_DAMP   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_CAL_PENDING = 2'd1,
      STATUS_ANALOGUE    = 2'd2,
      STATUS_BAD_REASON  = 2'd3
   } status_type;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [6:0] KEY_LEFT   = 7'd72;
   localparam logic [6:0] KEY_RIGHT  = 7'd74;
   localparam logic [6:0] KEY_CENTRE = 7'd73;
   localparam logic [6:0] KEY_UP     = 7'd56;
   localparam logic [6:0] KEY_DOWN   = 7'd91;
   localparam logic [6:0] KEY_FIRE1  = 7'd103;
   localparam logic [6:0] KEY_FIRE2  = 7'd75;

   typedef struct packed {
      logic [2:0] req_type;
      logic [6:0] key_code;
      logic       key_pressed;
      logic [7:0] stick_number;
      logic [7:0] reason;
   } item_type;

   typedef struct packed {
      logic        has_result;
      status_type  status;
      logic [31:0] position_word;
      logic [1:0]  button_bits;
      logic        is_emulated;
   } result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/kje_core.sv -----
`default_nettype none
module kje_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_write_data,
   input  wire kje_pkg::item_type item,
   input  wire logic              item_go,
   output kje_pkg::result_type    result
);

   localparam logic signed [19:0] DAMP_STEP  = 20'sd15360;
   localparam logic signed [19:0] DAMP_LIMIT = 20'sd130048;
   localparam logic signed [7:0]  SW_PLUS    = 8'sd64;
   localparam logic signed [7:0]  SW_MINUS   = -8'sd64;
   localparam logic signed [7:0]  ANA_EDGE   = 8'sd123;
   localparam logic signed [7:0]  ANA_MAX    = 8'sd127;
   localparam logic signed [7:0]  ANA_STEP   = 8'sd5;
   localparam logic [15:0]        CENTRE16   = 16'h7fff;

   kje_pkg::mode_type mode_ff, mode_in;
   logic signed [7:0]  x_ff, x_in, y_ff, y_in;
   logic        [1:0]  fire_ff, fire_in;
   logic               cal_tr_ff, cal_tr_in, cal_bl_ff, cal_bl_in;
   logic        [3:0]  held_ff, held_in;
   logic signed [19:0] damp_x_ff, damp_x_in, damp_y_ff, damp_y_in;

   function automatic logic signed [19:0] decay(input logic signed [19:0] v);
      return v - (v >>> 4) - (v >>> 5);
   endfunction

   function automatic logic signed [19:0] push_up(input logic signed [19:0] v);
      logic signed [19:0] t;
      t = v + DAMP_STEP;
      if (t < 0) t = t - (t >>> 2);
      if (t > DAMP_LIMIT) t = DAMP_LIMIT;
      return t;
   endfunction

   function automatic logic signed [19:0] push_down(input logic signed [19:0] v);
      logic signed [19:0] t;
      t = v - DAMP_STEP;
      if (t >= 0) t = t - (t >>> 2);
      if (t < -DAMP_LIMIT) t = -DAMP_LIMIT;
      return t;
   endfunction

   function automatic logic signed [7:0] ana_up(input logic signed [7:0] v);
      return (v < ANA_EDGE) ? v + ANA_STEP : ANA_MAX;
   endfunction

   function automatic logic signed [7:0] ana_down(input logic signed [7:0] v);
      return (v > -ANA_EDGE) ? v - ANA_STEP : -ANA_MAX;
   endfunction

   // state update
   always_comb begin
      logic [3:0] dir_bit;
      mode_in   = mode_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      fire_in   = fire_ff;
      cal_tr_in = cal_tr_ff;
      cal_bl_in = cal_bl_ff;
      held_in   = held_ff;
      damp_x_in = damp_x_ff;
      damp_y_in = damp_y_ff;
      dir_bit   = 4'b0000;
      if (csr_write_enable) begin
         if (csr_write_data != kje_pkg::MODE_UNUSED) begin
            mode_in   = kje_pkg::mode_type'(csr_write_data);
            x_in      = '0;
            y_in      = '0;
            cal_tr_in = 1'b0;
            cal_bl_in = 1'b0;
            if (csr_write_data == kje_pkg::MODE_DAMP) begin
               damp_x_in = '0;
               damp_y_in = '0;
            end
         end
      end else if (item_go) begin
         case (item.req_type)
            kje_pkg::REQ_KEY: begin
               if (item.key_code == kje_pkg::KEY_FIRE1) begin
                  fire_in = item.key_pressed ? (fire_ff | 2'b01) : (fire_ff & 2'b10);
               end else if (item.key_code == kje_pkg::KEY_FIRE2) begin
                  fire_in = item.key_pressed ? (fire_ff | 2'b10) : (fire_ff & 2'b01);
               end
               if (mode_ff == kje_pkg::MODE_SWITCH) begin
                  case (item.key_code)
                     kje_pkg::KEY_LEFT: begin
                        if (item.key_pressed) x_in = SW_MINUS;
                        else if (x_ff < 0) x_in = '0;
                     end
                     kje_pkg::KEY_RIGHT: begin
                        if (item.key_pressed) x_in = SW_PLUS;
                        else if (x_ff > 0) x_in = '0;
                     end
                     kje_pkg::KEY_UP: begin
                        if (item.key_pressed) y_in = SW_PLUS;
                        else if (y_ff > 0) y_in = '0;
                     end
                     kje_pkg::KEY_DOWN: begin
                        if (item.key_pressed) y_in = SW_MINUS;
                        else if (y_ff < 0) y_in = '0;
                     end
                     kje_pkg::KEY_CENTRE: begin
                        if (item.key_pressed) begin
                           x_in = '0;
                           y_in = '0;
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  case (item.key_code)
                     kje_pkg::KEY_LEFT:  dir_bit = 4'b0001;
                     kje_pkg::KEY_RIGHT: dir_bit = 4'b0010;
                     kje_pkg::KEY_UP:    dir_bit = 4'b0100;
                     kje_pkg::KEY_DOWN:  dir_bit = 4'b1000;
                     default:            dir_bit = 4'b0000;
                  endcase
                  held_in = item.key_pressed ? (held_ff | dir_bit) : (held_ff & ~dir_bit);
                  if (item.key_code == kje_pkg::KEY_CENTRE && item.key_pressed) begin
                     x_in      = '0;
                     y_in      = '0;
                     damp_x_in = '0;
                     damp_y_in = '0;
                  end
               end
            end
            kje_pkg::REQ_TICK: begin
               if (mode_ff == kje_pkg::MODE_DAMP) begin
                  damp_x_in = decay(damp_x_ff);
                  damp_y_in = decay(damp_y_ff);
                  if (held_ff[0]) damp_x_in = push_down(damp_x_in);
                  if (held_ff[1]) damp_x_in = push_up(damp_x_in);
                  if (held_ff[2]) damp_y_in = push_up(damp_y_in);
                  if (held_ff[3]) damp_y_in = push_down(damp_y_in);
               end else if (mode_ff == kje_pkg::MODE_ANALOG) begin
                  if (held_ff[0]) x_in = ana_down(x_in);
                  if (held_ff[1]) x_in = ana_up(x_in);
                  if (held_ff[2]) y_in = ana_up(y_in);
                  if (held_ff[3]) y_in = ana_down(y_in);
               end
            end
            kje_pkg::REQ_CAL_TR: begin
               if (mode_ff != kje_pkg::MODE_SWITCH) begin
                  if (!cal_bl_ff) cal_tr_in = 1'b1;
                  else cal_bl_in = 1'b0;
               end
            end
            kje_pkg::REQ_CAL_BL: begin
               if (mode_ff != kje_pkg::MODE_SWITCH) begin
                  if (!cal_tr_ff) cal_bl_in = 1'b1;
                  else cal_tr_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // result of the current item against the current state
   always_comb begin
      logic [7:0]  xb, yb;
      logic [15:0] x16, y16;
      if (mode_ff == kje_pkg::MODE_DAMP) begin
         xb  = damp_x_ff[17:10];
         yb  = damp_y_ff[17:10];
         x16 = CENTRE16 + damp_x_ff[17:2];
         y16 = CENTRE16 + damp_y_ff[17:2];
      end else begin
         xb  = x_ff;
         yb  = y_ff;
         x16 = CENTRE16 + {x_ff, 8'h00};
         y16 = CENTRE16 + {y_ff, 8'h00};
      end
      result               = '0;
      result.status        = kje_pkg::STATUS_OK;
      case (item.req_type)
         kje_pkg::REQ_READ8, kje_pkg::REQ_READ16: begin
            result.has_result = 1'b1;
            if (cal_tr_ff || cal_bl_ff) begin
               result.status = kje_pkg::STATUS_CAL_PENDING;
            end else if (item.stick_number != 8'd0) begin
               result.status = kje_pkg::STATUS_OK;
            end else if (item.reason > 8'd1) begin
               result.status = kje_pkg::STATUS_BAD_REASON;
            end else if (item.req_type == kje_pkg::REQ_READ8) begin
               result.position_word = {14'd0, fire_ff, xb, yb};
               result.button_bits   = fire_ff;
               result.is_emulated   = 1'b1;
            end else if (mode_ff == kje_pkg::MODE_SWITCH) begin
               result.status = kje_pkg::STATUS_ANALOGUE;
            end else begin
               result.position_word = {x16, y16};
               result.button_bits   = fire_ff;
               result.is_emulated   = 1'b1;
            end
         end
         kje_pkg::REQ_CAL_TR, kje_pkg::REQ_CAL_BL: begin
            result.has_result = 1'b1;
            if (mode_ff == kje_pkg::MODE_SWITCH) result.status = kje_pkg::STATUS_ANALOGUE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= kje_pkg::MODE_SWITCH;
         x_ff      <= '0;
         y_ff      <= '0;
         fire_ff   <= '0;
         cal_tr_ff <= 1'b0;
         cal_bl_ff <= 1'b0;
         held_ff   <= '0;
         damp_x_ff <= '0;
         damp_y_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         fire_ff   <= fire_in;
         cal_tr_ff <= cal_tr_in;
         cal_bl_ff <= cal_bl_in;
         held_ff   <= held_in;
         damp_x_ff <= damp_x_in;
         damp_y_ff <= damp_y_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/keypad_joystick_emulator.sv -----
// Keypad joystick emulator, joystick 0 driven from keypad key events.
// Request channel (req_*, valid/ready): key events, ticks, 8-bit and 16-bit
// reads and the two calibration calls. Key events and ticks only update
// state and give no response; reads and calibration calls give exactly one
// response transaction on the rsp_* channel.
// A request is captured in the input register and processed against the
// stick state once the output register can take a result; its response is
// then registered in the output register.
// Throughput: one request per cycle while the receiver takes responses;
// the state update is a single pass through the key/tick logic between the
// input register and the state and response registers.
// If the receiver stalls, the response holds in the output register, one
// request waits in the input register and req_ready drops until the
// response is taken.
// csr_write_enable/csr_write_data set the mode (0 switched, 1 analogue,
// 2 damped; 3 is ignored) and clear the axes and calibration flags; write
// only while no request is in flight.
// Reset: synchronous, active high; switched mode, axes centered, buttons
// and held keys released, no calibration pending, both channels empty.
`default_nettype none
`include "keypad_joystick_emulator_defines.svh"
module keypad_joystick_emulator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [6:0]  req_key_code,
   input  wire logic        req_key_pressed,
   input  wire logic [7:0]  req_stick_number,
   input  wire logic [7:0]  req_reason,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_position_word,
   output logic [1:0]       rsp_button_bits,
   output logic             rsp_is_emulated
);

   logic                item_valid_ff, item_valid_in;
   kje_pkg::item_type   item_ff, item_in;
   logic                item_go;
   kje_pkg::result_type result;
   logic                rsp_valid_ff, rsp_valid_in;
   kje_pkg::result_type rsp_ff, rsp_in;

   // an item is waiting and the output register can take a new result this cycle
   assign item_go   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || item_go;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_ready) begin
         item_valid_in        = req_valid;
         item_in.req_type     = req_type;
         item_in.key_code     = req_key_code;
         item_in.key_pressed  = req_key_pressed;
         item_in.stick_number = req_stick_number;
         item_in.reason       = req_reason;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (item_go) begin
         rsp_valid_in = result.has_result;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   kje_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item             (item_ff),
      .item_go          (item_go),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_position_word = rsp_ff.position_word;
   assign rsp_button_bits   = rsp_ff.button_bits;
   assign rsp_is_emulated   = rsp_ff.is_emulated;

   `KJE_ASSERT_NOW(a_error_zeroes, rsp_valid_ff && rsp_ff.status != kje_pkg::STATUS_OK, rsp_ff.position_word == 32'd0 && rsp_ff.button_bits == 2'd0 && !rsp_ff.is_emulated)
   `KJE_ASSERT_NOW(a_emulated_ok, rsp_valid_ff && rsp_ff.is_emulated, rsp_ff.status == kje_pkg::STATUS_OK)
   `KJE_ASSERT_NEXT(a_item_kept, item_valid_ff && !item_go, item_valid_ff && $stable(item_ff))
   `KJE_ASSERT_NEXT(a_result_loaded, item_go && result.has_result, rsp_valid_ff)
   `KJE_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_ready, !item_go)

endmodule
`default_nettype wire
